>>> rtl/ckl_pkg.sv
`timescale 1ns / 1ps
// ckl_pkg: request/response types, keyframe entry, microcode encoding and the program ROM
// of the cyclic keyframe color lerp unit. Depends on nothing; imported by every module.
package ckl_pkg;

    localparam int DAY_TICKS = 2880;
    localparam int TIME_W    = 12;   // key and query time in ticks
    localparam int SPAN_W    = 13;   // time after adding one day
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int ROW_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int CNT_IN_W  = 5;
    localparam int ACC_W     = 22;   // 2 * 255 * span + span < 2**22
    localparam int BIT_W     = 3;    // quotient bit counter
    localparam int STEP_W    = 5;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ROW_W-1:0]    row_index;
        logic [SLOT_W-1:0]   key_index;
        logic [CNT_IN_W-1:0] key_count;
        logic [TIME_W-1:0]   key_time;
        logic [COLOR_W-1:0]  key_color;
        logic [TIME_W-1:0]   query_time;
    } t_req;

    typedef struct packed {
        logic              is_query_result;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rsp;

    typedef struct packed {
        logic [TIME_W-1:0]  key_time;
        logic [COLOR_W-1:0] key_color;
    } t_key;

    typedef enum logic [1:0] {
        KIND_SET_COUNT = 2'd0,
        KIND_LOAD_KEY  = 2'd1,
        KIND_QUERY     = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        OP_NOP        = 5'd0,
        OP_ACCEPT     = 5'd1,
        OP_FETCH      = 5'd2,
        OP_WR_CNT     = 5'd3,
        OP_WR_KEY     = 5'd4,
        OP_KEY0       = 5'd5,
        OP_INIT_B     = 5'd6,
        OP_SCAN       = 5'd7,
        OP_WRAP_A     = 5'd8,
        OP_PREP       = 5'd9,
        OP_MUL1       = 5'd10,
        OP_MUL2       = 5'd11,
        OP_DIV_INIT   = 5'd12,
        OP_DIV        = 5'd13,
        OP_EMIT_ACK   = 5'd14,
        OP_EMIT_BLACK = 5'd15,
        OP_EMIT_KEY   = 5'd16,
        OP_EMIT_LERP  = 5'd17
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER        = 4'd0,
        C_ALWAYS       = 4'd1,
        C_NO_REQ       = 4'd2,
        C_SET_CNT      = 4'd3,
        C_LOAD         = 4'd4,
        C_NOT_QUERY    = 4'd5,
        C_EMPTY        = 4'd6,
        C_BEFORE_FIRST = 4'd7,
        C_SCAN_MORE    = 4'd8,
        C_DEGEN        = 4'd9,
        C_DIV_MORE     = 4'd10
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic no_req;
        logic set_cnt;
        logic load;
        logic not_query;
        logic empty;
        logic before_first;
        logic scan_more;
        logic degen;
        logic div_more;
        logic stall;
    } t_flags;

    typedef struct packed {
        logic cnt_wr;
        logic cnt_rd;
        logic key_wr;
        logic key_rd;
    } t_store_ctl;

    localparam logic [STEP_W-1:0] S_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] S_FETCH      = 5'd1;
    localparam logic [STEP_W-1:0] S_IS_LOAD    = 5'd2;
    localparam logic [STEP_W-1:0] S_IS_QUERY   = 5'd3;
    localparam logic [STEP_W-1:0] S_KEY0       = 5'd4;
    localparam logic [STEP_W-1:0] S_LAST_KEY   = 5'd5;
    localparam logic [STEP_W-1:0] S_SCAN       = 5'd6;
    localparam logic [STEP_W-1:0] S_PREP       = 5'd7;
    localparam logic [STEP_W-1:0] S_MUL1       = 5'd8;
    localparam logic [STEP_W-1:0] S_MUL2       = 5'd9;
    localparam logic [STEP_W-1:0] S_DIV_INIT   = 5'd10;
    localparam logic [STEP_W-1:0] S_DIV        = 5'd11;
    localparam logic [STEP_W-1:0] S_EMIT_LERP  = 5'd12;
    localparam logic [STEP_W-1:0] S_WRAP       = 5'd13;
    localparam logic [STEP_W-1:0] S_EMIT_KEY   = 5'd14;
    localparam logic [STEP_W-1:0] S_EMIT_BLACK = 5'd15;
    localparam logic [STEP_W-1:0] S_SET_CNT    = 5'd16;
    localparam logic [STEP_W-1:0] S_EMIT_ACK   = 5'd17;
    localparam logic [STEP_W-1:0] S_LOAD       = 5'd18;
    localparam logic [STEP_W-1:0] S_PROG_END   = S_LOAD;

    // Program ROM: jump to target when the condition holds, else fall through.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            S_IDLE:       w = '{OP_ACCEPT,     C_NO_REQ,       S_IDLE};
            S_FETCH:      w = '{OP_FETCH,      C_SET_CNT,      S_SET_CNT};
            S_IS_LOAD:    w = '{OP_NOP,        C_LOAD,         S_LOAD};
            S_IS_QUERY:   w = '{OP_NOP,        C_NOT_QUERY,    S_EMIT_ACK};
            S_KEY0:       w = '{OP_KEY0,       C_EMPTY,        S_EMIT_BLACK};
            S_LAST_KEY:   w = '{OP_INIT_B,     C_BEFORE_FIRST, S_WRAP};
            S_SCAN:       w = '{OP_SCAN,       C_SCAN_MORE,    S_SCAN};
            S_PREP:       w = '{OP_PREP,       C_DEGEN,        S_EMIT_KEY};
            S_MUL1:       w = '{OP_MUL1,       C_NEVER,        S_IDLE};
            S_MUL2:       w = '{OP_MUL2,       C_NEVER,        S_IDLE};
            S_DIV_INIT:   w = '{OP_DIV_INIT,   C_NEVER,        S_IDLE};
            S_DIV:        w = '{OP_DIV,        C_DIV_MORE,     S_DIV};
            S_EMIT_LERP:  w = '{OP_EMIT_LERP,  C_ALWAYS,       S_IDLE};
            S_WRAP:       w = '{OP_WRAP_A,     C_ALWAYS,       S_PREP};
            S_EMIT_KEY:   w = '{OP_EMIT_KEY,   C_ALWAYS,       S_IDLE};
            S_EMIT_BLACK: w = '{OP_EMIT_BLACK, C_ALWAYS,       S_IDLE};
            S_SET_CNT:    w = '{OP_WR_CNT,     C_NEVER,        S_IDLE};
            S_EMIT_ACK:   w = '{OP_EMIT_ACK,   C_ALWAYS,       S_IDLE};
            S_LOAD:       w = '{OP_WR_KEY,     C_ALWAYS,       S_EMIT_ACK};
            default:      w = '{OP_ACCEPT,     C_NO_REQ,       S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/cyclic_keyframe_color_lerp_unit.sv
`timescale 1ns / 1ps
// cyclic_keyframe_color_lerp_unit: top level; request latch, search and span datapath,
// output register. Depends on ckl_pkg, ckl_seq, ckl_store and ckl_lane.

// One request is worked at a time, stepped by a microcoded sequencer. A query walks the
// row's keys from the last one down, one key per cycle through the single keyframe memory
// port, then forms the weighted channel sums and divides them bit-serially, one quotient
// bit per cycle for all three channels at once. A query of an empty or out-of-range row
// answers black, a time before the first key spans from the last key to the first key a
// day later, and an empty span gives the lower key's color without the divide. A new
// request is taken as soon as the previous result sits in the output register, and the
// sequencer holds only when that register is still full at the next result. No clearing
// pass is needed after reset.
module cyclic_keyframe_color_lerp_unit #(
    parameter int ROWS     = 32,
    parameter int MAX_KEYS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ckl_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ckl_pkg::t_rsp o_out_rsp
);
    import ckl_pkg::*;

    localparam int DEPTH = ROWS * MAX_KEYS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_KEYS + 1);

    t_ctrl      ctrl;
    t_flags     flags;
    t_store_ctl sctl;

    t_req               r_req;
    logic [SPAN_W-1:0]  r_qt;
    logic [KW-1:0]      r_i;
    logic [TIME_W-1:0]  r_t0;
    logic [COLOR_W-1:0] r_c0;
    logic [SPAN_W-1:0]  r_ta;
    logic [SPAN_W-1:0]  r_tb;
    logic [COLOR_W-1:0] r_ca;
    logic [COLOR_W-1:0] r_cb;
    logic [SPAN_W-1:0]  r_den;
    logic [SPAN_W-1:0]  r_num;
    logic [SPAN_W-1:0]  r_wgt;
    logic [BIT_W-1:0]   r_bit;
    logic               r_out_vld;
    t_rsp               r_out;

    logic                  in_take;
    logic                  is_emit;
    logic                  row_ok;
    logic                  slot_ok;
    logic [RW+ROW_W-1:0]   row_ext;
    logic [KW+SLOT_W-1:0]  slot_ext;
    logic [RW-1:0]         row_idx;
    logic [KW-1:0]         slot_idx;
    logic [KW-1:0]         key_sel;
    logic [AW-1:0]         key_addr;
    logic [CW-1:0]         cnt_sat;
    logic [CW-1:0]         cnt;
    logic [TIME_W-1:0]     qt_wrap;
    logic [TIME_W-1:0]     kt_wrap;
    t_key                  key_wdata;
    t_key                  rd;
    logic [SPAN_W-1:0]     span;
    logic [SPAN_W-1:0]     num_raw;
    logic [SPAN_W-1:0]     num_clamp;
    logic                  scan_more;
    t_rsp                  n_out;
    logic [CHAN_W-1:0]     q_r;
    logic [CHAN_W-1:0]     q_g;
    logic [CHAN_W-1:0]     q_b;

    ckl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign o_in_ready = (ctrl.op == OP_ACCEPT);
    assign in_take    = i_in_valid && o_in_ready;
    assign is_emit    = ctrl.op inside {OP_EMIT_ACK, OP_EMIT_BLACK, OP_EMIT_KEY, OP_EMIT_LERP};

    // Times at or above one day fold back by one day.
    assign qt_wrap = (i_in_req.query_time >= TIME_W'(DAY_TICKS)) ?
                     i_in_req.query_time - TIME_W'(DAY_TICKS) : i_in_req.query_time;
    assign kt_wrap = (r_req.key_time >= TIME_W'(DAY_TICKS)) ?
                     r_req.key_time - TIME_W'(DAY_TICKS) : r_req.key_time;

    assign row_ok   = int'(r_req.row_index) < ROWS;
    assign slot_ok  = int'(r_req.key_index) < MAX_KEYS;
    assign row_ext  = {{RW{1'b0}}, r_req.row_index};
    assign slot_ext = {{KW{1'b0}}, r_req.key_index};
    assign row_idx  = row_ext[RW-1:0];
    assign slot_idx = slot_ext[KW-1:0];
    assign cnt_sat  = (int'(r_req.key_count) > MAX_KEYS) ? CW'(MAX_KEYS) :
                                                             CW'(r_req.key_count);

    assign scan_more = (r_i != '0) && (SPAN_W'(rd.key_time) > r_qt);

    always_comb begin
        if (ctrl.op == OP_WR_KEY) begin
            key_sel = slot_idx;
        end else if (ctrl.op == OP_FETCH) begin
            key_sel = '0;
        end else if (ctrl.op == OP_SCAN) begin
            key_sel = r_i - KW'(1);
        end else begin
            key_sel = r_i;
        end
    end

    assign key_addr = AW'(row_idx) * AW'(MAX_KEYS) + AW'(key_sel);

    assign key_wdata.key_time  = kt_wrap;
    assign key_wdata.key_color = r_req.key_color;

    assign sctl.cnt_wr = (ctrl.op == OP_WR_CNT) && row_ok;
    assign sctl.cnt_rd = (ctrl.op == OP_FETCH) && row_ok;
    assign sctl.key_wr = (ctrl.op == OP_WR_KEY) && row_ok && slot_ok;
    assign sctl.key_rd = row_ok && ((ctrl.op == OP_FETCH) || (ctrl.op == OP_INIT_B) ||
                                    ((ctrl.op == OP_SCAN) && scan_more));

    ckl_store #(
        .ROWS     (ROWS),
        .MAX_KEYS (MAX_KEYS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sctl),
        .i_row       (row_idx),
        .i_key_addr  (key_addr),
        .i_cnt_wdata (cnt_sat),
        .i_key_wdata (key_wdata),
        .o_cnt       (cnt),
        .o_key       (rd)
    );

    assign flags.no_req       = !i_in_valid;
    assign flags.set_cnt      = (r_req.kind == KIND_SET_COUNT);
    assign flags.load         = (r_req.kind == KIND_LOAD_KEY);
    assign flags.not_query    = (r_req.kind != KIND_QUERY);
    assign flags.empty        = !row_ok || (cnt == '0);
    assign flags.before_first = r_qt < SPAN_W'(r_t0);
    assign flags.scan_more    = scan_more;
    assign flags.degen        = (r_tb <= r_ta) || (r_qt < r_ta);
    assign flags.div_more     = (r_bit != '0);
    assign flags.stall        = is_emit && r_out_vld && !i_out_ready;

    assign span      = r_tb - r_ta;
    assign num_raw   = r_qt - r_ta;
    assign num_clamp = (num_raw > span) ? span : num_raw;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in_req;
            r_qt  <= SPAN_W'(qt_wrap);
        end
        case (ctrl.op)
            OP_KEY0: begin
                r_t0 <= rd.key_time;
                r_c0 <= rd.key_color;
                r_i  <= KW'(cnt - CW'(1));
            end
            OP_INIT_B: begin
                // Upper key defaults to the first key one day later.
                r_tb <= SPAN_W'(r_t0) + SPAN_W'(DAY_TICKS);
                r_cb <= r_c0;
            end
            OP_SCAN: begin
                if (scan_more) begin
                    r_tb <= SPAN_W'(rd.key_time);
                    r_cb <= rd.key_color;
                    r_i  <= r_i - KW'(1);
                end else begin
                    r_ta <= SPAN_W'(rd.key_time);
                    r_ca <= rd.key_color;
                end
            end
            OP_WRAP_A: begin
                r_ta <= SPAN_W'(rd.key_time);
                r_ca <= rd.key_color;
                r_qt <= r_qt + SPAN_W'(DAY_TICKS);
            end
            OP_PREP: begin
                r_den <= span;
                r_num <= num_clamp;
                r_wgt <= span - num_clamp;
            end
            OP_DIV_INIT: r_bit <= BIT_W'(CHAN_W - 1);
            OP_DIV:      r_bit <= r_bit - BIT_W'(1);
            default: ;
        endcase
    end

    ckl_lane u_lane_r (
        .i_clk (i_clk),
        .i_op  (ctrl.op),
        .i_c1  (r_ca[23:16]),
        .i_c2  (r_cb[23:16]),
        .i_num (r_num),
        .i_wgt (r_wgt),
        .i_den (r_den),
        .o_q   (q_r)
    );

    ckl_lane u_lane_g (
        .i_clk (i_clk),
        .i_op  (ctrl.op),
        .i_c1  (r_ca[15:8]),
        .i_c2  (r_cb[15:8]),
        .i_num (r_num),
        .i_wgt (r_wgt),
        .i_den (r_den),
        .o_q   (q_g)
    );

    ckl_lane u_lane_b (
        .i_clk (i_clk),
        .i_op  (ctrl.op),
        .i_c1  (r_ca[7:0]),
        .i_c2  (r_cb[7:0]),
        .i_num (r_num),
        .i_wgt (r_wgt),
        .i_den (r_den),
        .o_q   (q_b)
    );

    always_comb begin
        n_out = '0;
        case (ctrl.op)
            OP_EMIT_BLACK: n_out.is_query_result = 1'b1;
            OP_EMIT_KEY: begin
                n_out.is_query_result = 1'b1;
                n_out.red             = r_ca[23:16];
                n_out.green           = r_ca[15:8];
                n_out.blue            = r_ca[7:0];
            end
            OP_EMIT_LERP: begin
                n_out.is_query_result = 1'b1;
                n_out.red             = q_r;
                n_out.green           = q_g;
                n_out.blue            = q_b;
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (is_emit && !flags.stall) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_emit && !flags.stall) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_in_ready)
        else $error("sequencer stayed ready after taking a request");

    a_scan_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_SCAN) |-> (int'(r_i) < int'(cnt)))
        else $error("key scan pointer beyond the row's key count");

    a_num_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_MUL1) |-> (r_num <= r_den))
        else $error("interpolation offset exceeds the key span");

endmodule

>>> rtl/ckl_seq.sv
`timescale 1ns / 1ps
// ckl_seq: step counter and program ROM lookup; picks the next step from the condition flags.
// Depends on ckl_pkg (control word, flags, program).
module ckl_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ckl_pkg::t_flags i_flags,
    output ckl_pkg::t_ctrl  o_ctrl
);
    import ckl_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctrl             uw;
    logic              take;

    assign uw     = ucode(r_pc);
    assign o_ctrl = uw;

    always_comb begin
        case (uw.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_REQ:       take = i_flags.no_req;
            C_SET_CNT:      take = i_flags.set_cnt;
            C_LOAD:         take = i_flags.load;
            C_NOT_QUERY:    take = i_flags.not_query;
            C_EMPTY:        take = i_flags.empty;
            C_BEFORE_FIRST: take = i_flags.before_first;
            C_SCAN_MORE:    take = i_flags.scan_more;
            C_DEGEN:        take = i_flags.degen;
            C_DIV_MORE:     take = i_flags.div_more;
            default:        take = 1'b0;
        endcase
    end

    always_comb begin
        if (i_flags.stall) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= S_PROG_END)
        else $error("step counter left the program");

endmodule

>>> rtl/ckl_store.sv
`timescale 1ns / 1ps
// ckl_store: keyframe memory (one port, registered read) and per-row key count memory
// with reset-cleared valid bits. Depends on ckl_pkg (t_key, t_store_ctl).
module ckl_store #(
    parameter  int ROWS     = 32,
    parameter  int MAX_KEYS = 16,
    localparam int DEPTH    = ROWS * MAX_KEYS,
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW       = $clog2(MAX_KEYS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ckl_pkg::t_store_ctl i_ctl,
    input  logic [RW-1:0]       i_row,
    input  logic [AW-1:0]       i_key_addr,
    input  logic [CW-1:0]       i_cnt_wdata,
    input  ckl_pkg::t_key       i_key_wdata,
    output logic [CW-1:0]       o_cnt,
    output ckl_pkg::t_key       o_key
);
    import ckl_pkg::*;

    t_key            r_key_mem [DEPTH];
    logic [CW-1:0]   r_cnt_mem [ROWS];
    logic [ROWS-1:0] r_cnt_vld;
    t_key            r_key_rd;
    logic [CW-1:0]   r_cnt_rd;
    logic            r_cnt_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_wr) begin
            r_key_mem[i_key_addr] <= i_key_wdata;
        end
        if (i_ctl.key_rd) begin
            r_key_rd <= r_key_mem[i_key_addr];
        end
        if (i_ctl.cnt_wr) begin
            r_cnt_mem[i_row] <= i_cnt_wdata;
        end
        if (i_ctl.cnt_rd) begin
            r_cnt_rd <= r_cnt_mem[i_row];
        end
    end

    // A row never written reads as zero keys.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld    <= '0;
            r_cnt_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.cnt_wr) begin
                r_cnt_vld[i_row] <= 1'b1;
            end
            if (i_ctl.cnt_rd) begin
                r_cnt_rd_vld <= r_cnt_vld[i_row];
            end
        end
    end

    assign o_cnt = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign o_key = r_key_rd;

endmodule

>>> rtl/ckl_lane.sv
`timescale 1ns / 1ps
// ckl_lane: one color channel: weighted sum through a shared multiplier, then a bit-serial
// restoring divide giving round(sum / span). Depends on ckl_pkg (t_op, widths).
module ckl_lane (
    input  logic                        i_clk,
    input  ckl_pkg::t_op                i_op,
    input  logic [ckl_pkg::CHAN_W-1:0]  i_c1,
    input  logic [ckl_pkg::CHAN_W-1:0]  i_c2,
    input  logic [ckl_pkg::SPAN_W-1:0]  i_num,
    input  logic [ckl_pkg::SPAN_W-1:0]  i_wgt,
    input  logic [ckl_pkg::SPAN_W-1:0]  i_den,
    output logic [ckl_pkg::CHAN_W-1:0]  o_q
);
    import ckl_pkg::*;

    localparam int PROD_W = CHAN_W + SPAN_W;
    localparam int DSH_W  = SPAN_W + CHAN_W;

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [DSH_W-1:0]  r_dsh;
    logic [DSH_W-1:0]  n_dsh;
    logic [CHAN_W-1:0] r_q;
    logic [CHAN_W-1:0] n_q;
    logic [CHAN_W-1:0] mul_c;
    logic [SPAN_W-1:0] mul_s;
    logic [PROD_W-1:0] prod;

    assign mul_c = (i_op == OP_MUL1) ? i_c1 : i_c2;
    assign mul_s = (i_op == OP_MUL1) ? i_wgt : i_num;
    assign prod  = {{SPAN_W{1'b0}}, mul_c} * {{CHAN_W{1'b0}}, mul_s};

    always_comb begin
        n_acc = r_acc;
        n_dsh = r_dsh;
        n_q   = r_q;
        case (i_op)
            OP_MUL1: n_acc = ACC_W'(prod);
            OP_MUL2: n_acc = r_acc + ACC_W'(prod);
            OP_DIV_INIT: begin
                // dividend 2*sum + span, divisor 2*span aligned to the top quotient bit
                n_acc = {r_acc[ACC_W-2:0], 1'b0} + ACC_W'(i_den);
                n_dsh = {i_den, {CHAN_W{1'b0}}};
                n_q   = '0;
            end
            OP_DIV: begin
                if (ACC_W'(r_dsh) <= r_acc) begin
                    n_acc = r_acc - ACC_W'(r_dsh);
                    n_q   = {r_q[CHAN_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[CHAN_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for cyclic_keyframe_color_lerp_unit; a local color predictor
// follows every accepted request. Depends on ckl_pkg and the unit's RTL.
module tb_top;
    import ckl_pkg::*;

    localparam int ROWS        = 32;
    localparam int MAX_KEYS    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 340;
    localparam int N_TAIL      = 60;
    localparam int SETTLE      = 40;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in_req    = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_rsp;

    cyclic_keyframe_color_lerp_unit #(
        .ROWS     (ROWS),
        .MAX_KEYS (MAX_KEYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the keyframe table and row counts
    t_key                key_mem     [ROWS][MAX_KEYS];
    logic [MAX_KEYS-1:0] key_written [ROWS] = '{default: '0};
    int unsigned         key_cnt     [ROWS] = '{default: 0};
    t_rsp                rsp_due[$];

    int n_items   = 0;
    int n_queries = 0;
    int n_errors  = 0;
    int cycle_cnt = 0;
    int hold_len  = 0;
    bit gaps_on   = 1'b1;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("cyclic_keyframe_color_lerp_unit test failed");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("ERROR cycle %0d: %s", cycle_cnt, what);
    endtask

    function automatic logic [TIME_W-1:0] wrap_tick(input logic [TIME_W-1:0] t);
        return (t >= DAY_TICKS) ? TIME_W'(t - DAY_TICKS) : t;
    endfunction

    function automatic logic [CHAN_W-1:0] blend(input int unsigned c1, input int unsigned c2,
                                                input int unsigned num, input int unsigned den);
        int unsigned sum;
        sum = c1 * (den - num) + c2 * num;
        return CHAN_W'((2 * sum + den) / (2 * den));
    endfunction

    // Apply one request to the shadow state and return the color it must produce
    function automatic t_rsp lerp_response(input t_req req);
        t_rsp               rsp;
        int unsigned        n, last, t, t0, t1, t2, i, den, num;
        logic [COLOR_W-1:0] c1, c2;
        logic [ROW_W-1:0]   r;
        rsp = '0;
        r   = req.row_index;
        case (req.kind)
            KIND_SET_COUNT: begin
                key_cnt[r] = (req.key_count > MAX_KEYS) ? MAX_KEYS : req.key_count;
            end
            KIND_LOAD_KEY: begin
                key_mem[r][req.key_index].key_time  = wrap_tick(req.key_time);
                key_mem[r][req.key_index].key_color = req.key_color;
                key_written[r][req.key_index]       = 1'b1;
            end
            KIND_QUERY: begin
                rsp.is_query_result = 1'b1;
                n = key_cnt[r];
                if (n != 0) begin
                    last = n - 1;
                    t    = wrap_tick(req.query_time);
                    t0   = key_mem[r][0].key_time;
                    if (t < t0) begin
                        // wrap from the last key to the first key of the next day
                        c1 = key_mem[r][last].key_color;
                        c2 = key_mem[r][0].key_color;
                        t1 = key_mem[r][last].key_time;
                        t2 = t0 + DAY_TICKS;
                        t  = t + DAY_TICKS;
                    end else begin
                        i = last;
                        while (i > 0 && key_mem[r][i].key_time > t)
                            i--;
                        c1 = key_mem[r][i].key_color;
                        t1 = key_mem[r][i].key_time;
                        if (i == last) begin
                            c2 = key_mem[r][0].key_color;
                            t2 = t0 + DAY_TICKS;
                        end else begin
                            c2 = key_mem[r][i+1].key_color;
                            t2 = key_mem[r][i+1].key_time;
                        end
                    end
                    if (t2 <= t1 || t < t1) begin
                        {rsp.red, rsp.green, rsp.blue} = c1;
                    end else begin
                        den = t2 - t1;
                        num = t - t1;
                        if (num > den)
                            num = den;
                        rsp.red   = blend(c1[23:16], c2[23:16], num, den);
                        rsp.green = blend(c1[15:8],  c2[15:8],  num, den);
                        rsp.blue  = blend(c1[7:0],   c2[7:0],   num, den);
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic bit row_is_loaded(input int unsigned row);
        for (int i = 0; i < key_cnt[row]; i++)
            if (!key_written[row][i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q = {$urandom(), $urandom()};
        return q;
    endfunction

    task automatic send_item(input t_req req);
        int gap;
        bit took;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        rsp_due = {rsp_due, lerp_response(req)};
        n_items++;
        if (req.kind == KIND_QUERY)
            n_queries++;
    endtask

    task automatic send_count(input int unsigned row, input int unsigned cnt);
        t_req q;
        q = rand_req();
        q.kind      = KIND_SET_COUNT;
        q.row_index = ROW_W'(row);
        q.key_count = CNT_IN_W'(cnt);
        send_item(q);
    endtask

    task automatic send_key(input int unsigned row, input int unsigned slot,
                            input int unsigned tm, input logic [COLOR_W-1:0] col);
        t_req q;
        q = rand_req();
        q.kind      = KIND_LOAD_KEY;
        q.row_index = ROW_W'(row);
        q.key_index = SLOT_W'(slot);
        q.key_time  = TIME_W'(tm);
        q.key_color = col;
        send_item(q);
    endtask

    task automatic send_query(input int unsigned row, input int unsigned tm);
        t_req q;
        q = rand_req();
        q.kind       = KIND_QUERY;
        q.row_index  = ROW_W'(row);
        q.query_time = TIME_W'(tm);
        send_item(q);
    endtask

    // Drop valid and hold the sender until every request has been answered
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_noise();
        t_req q;
        q = rand_req();
        // never query a row whose counted slots are not all loaded
        if (q.kind == KIND_QUERY && !row_is_loaded(q.row_index))
            q.kind = KIND_NONE;
        send_item(q);
    endtask

    // Load a row with n keys and a count, then query it at a few times
    task automatic program_row(input int unsigned row, input int unsigned n_q);
        int unsigned n, step, cnt_field, qt, tm;
        int unsigned tk [MAX_KEYS];
        bit          shuffled, count_first;
        n         = ($urandom_range(0, 5) == 0) ? MAX_KEYS : $urandom_range(0, MAX_KEYS);
        cnt_field = (n == MAX_KEYS && $urandom_range(0, 1)) ? $urandom_range(MAX_KEYS, 31) : n;
        shuffled  = ($urandom_range(0, 5) == 0);
        step      = (n == 0) ? DAY_TICKS : DAY_TICKS / n;
        for (int i = 0; i < n; i++) begin
            if (shuffled)
                tk[i] = $urandom_range(0, DAY_TICKS - 1);
            else if (i == 0)
                tk[i] = $urandom_range(0, step - 1);
            else begin
                tk[i] = tk[i-1] + $urandom_range(0, step);
                if (tk[i] > DAY_TICKS - 1)
                    tk[i] = DAY_TICKS - 1;
            end
        end
        count_first = $urandom_range(0, 1);
        if (count_first)
            send_count(row, cnt_field);
        for (int i = 0; i < n; i++) begin
            // sometimes encode the time one day late
            tm = (tk[i] <= 4095 - DAY_TICKS && $urandom_range(0, 3) == 0) ?
                 tk[i] + DAY_TICKS : tk[i];
            send_key(row, i, tm, COLOR_W'($urandom()));
        end
        if (!count_first)
            send_count(row, cnt_field);
        for (int k = 0; k < n_q; k++) begin
            if (n != 0 && $urandom_range(0, 1)) begin
                qt = tk[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
                if (qt > 4095)
                    qt = 0;
            end else begin
                qt = $urandom_range(0, 4095);
            end
            send_query(row, qt);
        end
    endtask

    task automatic run_mix(input int count);
        int target;
        target = n_items + count;
        while (n_items < target) begin
            if ($urandom_range(0, 9) < 7)
                program_row($urandom_range(0, ROWS - 1), $urandom_range(2, 6));
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
        wait_for_results();
    endtask

    task automatic test_directed_lerp();
        send_key(1, 0, 600,  24'hFF0000);
        send_key(1, 1, 1200, 24'h00FF00);
        send_key(1, 2, 2879, 24'hFFFFFF);
        send_count(1, 3);
        send_query(1, 900);
        send_query(1, 600);
        send_query(1, 0);
        send_query(1, 2879);
        send_query(1, 4095);
        send_query(1, 1500);
        wait_for_results();
    endtask

    task automatic test_directed_edges();
        t_req q;
        send_query(0, 1234);            // empty row answers black
        q = '1;                         // unknown kind with every field at its top
        send_item(q);
        send_key(2, 0, 4095, 24'h123456);
        send_count(2, 1);
        send_query(2, 0);
        send_query(2, 2000);
        // two keys at one time, then a later one
        send_key(3, 0, 100, 24'h00FF00);
        send_key(3, 1, 100, 24'hFF00FF);
        send_key(3, 2, 700, 24'h000000);
        send_count(3, 3);
        send_query(3, 100);
        send_query(3, 50);
        send_query(3, 400);
        wait_for_results();
    endtask

    task automatic test_random_rows();
        run_mix(N_RANDOM);
    endtask

    // Hold the output off long enough that the unit fills and stalls its input
    task automatic test_output_backpressure();
        bit saved;
        saved    = gaps_on;
        gaps_on  = 1'b0;
        hold_len = 200;
        repeat (2) @(posedge i_clk);
        repeat (12) send_noise();
        gaps_on = saved;
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        run_mix(N_TAIL);
    endtask

    initial begin : out_ready_ctl
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : rsp_check
        t_rsp got;
        t_rsp exp;
        bit   fire;
        forever begin
            @(negedge i_clk);
            fire = o_out_valid && i_out_ready && i_rst_n;
            got  = o_out_rsp;
            @(posedge i_clk);
            if (fire) begin
                if (rsp_due.size() == 0) begin
                    report($sformatf("result %h with no request outstanding", got));
                end else begin
                    exp = rsp_due.pop_front();
                    if (got.is_query_result !== exp.is_query_result)
                        report($sformatf("is_query_result %b, want %b",
                                         got.is_query_result, exp.is_query_result));
                    if (got.red !== exp.red)
                        report($sformatf("red %h, want %h", got.red, exp.red));
                    if (got.green !== exp.green)
                        report($sformatf("green %h, want %h", got.green, exp.green));
                    if (got.blue !== exp.blue)
                        report($sformatf("blue %h, want %h", got.blue, exp.blue));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_lerp();
        test_directed_edges();
        test_random_rows();
        test_output_backpressure();
        test_steady_stream();
        repeat (SETTLE) @(posedge i_clk);
        if (rsp_due.size() != 0)
            report($sformatf("%0d results never arrived", rsp_due.size()));
        $display("Run covered %0d requests (%0d color queries) over %0d cycles,",
                 n_items, n_queries, cycle_cnt);
        $display("with random stalls on both channels, one long output hold and a gap-free tail.");
        if (n_errors == 0)
            $display("cyclic_keyframe_color_lerp_unit test passed");
        else
            $display("cyclic_keyframe_color_lerp_unit test failed");
        $finish;
    end

endmodule
